// ----- hw/rtl/gmmf_pkg.sv -----
// gmmf_pkg: shared constants, command/status structs and controller states
// for the gas mixture mole fraction update block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gmmf_pkg;

    localparam int NUM_COMPOUNDS = 4;
    localparam int IDX_W         = $clog2(NUM_COMPOUNDS);

    localparam int FRAC_W    = 17;
    localparam int HEAT_W    = 16;
    localparam int OLD_W     = 31;
    localparam int ADD_W     = 32;
    localparam int CFG_IDX_W = 8;

    // weight arithmetic
    localparam int OLD_PROD_W = OLD_W + FRAC_W;
    localparam int ADD_PROD_W = ADD_W + FRAC_W + 1;
    localparam int SUM_W      = ADD_PROD_W + 1;
    localparam int V_W        = SUM_W - 1;
    localparam int TOT_W      = V_W + IDX_W;

    // heat arithmetic
    localparam int HPROD_W = HEAT_W + FRAC_W;
    localparam int HACC_W  = HPROD_W + IDX_W;
    localparam int HFRAC_BITS = 16;

    // divider: one integer step, sixteen fraction steps, one rounding step
    localparam int DIV_LAST  = FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_LAST + 1);

    localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
    localparam logic [HEAT_W-1:0] HEAT_RESET = 16'd7424;
    localparam logic [HEAT_W-1:0] HEAT_MAX   = 16'hFFFF;

    localparam logic OP_MIX  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef logic [NUM_COMPOUNDS-1:0][FRAC_W-1:0] frac_vec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WACC,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HMUL,
        ST_HACC,
        ST_FINISH
    } gmmf_state_t;

    typedef struct packed {
        logic load_in;
        logic idx_clr;
        logic idx_inc;
        logic wmul;
        logic wacc;
        logic frac_copy;
        logic frac_first;
        logic div_start;
        logic div_store;
        logic hmul;
        logic hacc;
        logic out_load;
    } gmmf_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic op_load;
        logic sum_one;
        logic total_zero;
        logic div_done;
    } gmmf_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gmmf_div.sv -----
// gmmf_div: iterative restoring divider giving a rounded Q1.16 quotient
// num * 65536 / den with num <= den; uses gmmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmmf_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gmmf_pkg::TOT_W-1:0]    num,
    input  wire logic [gmmf_pkg::TOT_W-1:0]    den,
    output logic                               done,
    output logic [gmmf_pkg::FRAC_W-1:0]        quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [gmmf_pkg::DIV_CNT_W-1:0]    step_reg, step_next;
    logic [gmmf_pkg::TOT_W:0]          rem_reg, rem_next;
    logic [gmmf_pkg::TOT_W-1:0]        den_reg, den_next;
    logic [gmmf_pkg::FRAC_W-1:0]       q_reg, q_next;

    logic [gmmf_pkg::TOT_W:0]          shifted;
    logic                              ge;

    // first step compares without shifting
    assign shifted = (step_reg == '0) ? rem_reg : {rem_reg[gmmf_pkg::TOT_W-1:0], 1'b0};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == gmmf_pkg::DIV_CNT_W'(gmmf_pkg::DIV_LAST))
            begin
                // round half up
                q_next    = q_reg + gmmf_pkg::FRAC_W'(ge);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = ge ? (shifted - {1'b0, den_reg}) : shifted;
                q_next    = {q_reg[gmmf_pkg::FRAC_W-2:0], ge};
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gmmf_dp.sv -----
// gmmf_dp: datapath with mixture state, heat registers, weight and heat
// multipliers, output registers; uses gmmf_pkg and gmmf_div
`timescale 1ns / 1ps
`default_nettype none

module gmmf_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gmmf_pkg::gmmf_cmd_t               cmd,
    output gmmf_pkg::gmmf_stat_t                   stat,
    input  wire logic                              opcode,
    input  wire logic [gmmf_pkg::OLD_W-1:0]        old_moles,
    input  wire logic signed [gmmf_pkg::ADD_W-1:0] add_moles,
    input  wire gmmf_pkg::frac_vec_t               frac_in,
    input  wire logic                              cfg_we,
    input  wire logic [gmmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gmmf_pkg::HEAT_W-1:0]       cfg_data,
    output gmmf_pkg::frac_vec_t                    frac_out,
    output logic [gmmf_pkg::HEAT_W-1:0]            mix_heat,
    output logic                                   was_normalized
);

    localparam int HSH_W = gmmf_pkg::HACC_W + 1 - gmmf_pkg::HFRAC_BITS;

    // latched request
    logic                                   opcode_reg;
    logic [gmmf_pkg::OLD_W-1:0]             old_reg;
    logic signed [gmmf_pkg::ADD_W-1:0]      add_reg;
    gmmf_pkg::frac_vec_t                    fin_reg;

    logic [gmmf_pkg::IDX_W-1:0]             idx_reg;
    gmmf_pkg::frac_vec_t                    mole_frac_reg;
    logic [gmmf_pkg::HEAT_W-1:0]            heat_cap_reg [gmmf_pkg::NUM_COMPOUNDS];

    logic [gmmf_pkg::OLD_PROD_W-1:0]        old_prod_reg;
    logic signed [gmmf_pkg::ADD_PROD_W-1:0] add_prod_reg;
    logic [gmmf_pkg::V_W-1:0]               v_reg [gmmf_pkg::NUM_COMPOUNDS];
    logic [gmmf_pkg::TOT_W-1:0]             total_reg;
    logic                                   normed_reg;

    logic [gmmf_pkg::HPROD_W-1:0]           hprod_reg;
    logic [gmmf_pkg::HACC_W-1:0]            hacc_reg;

    gmmf_pkg::frac_vec_t                    frac_out_reg;
    logic [gmmf_pkg::HEAT_W-1:0]            heat_out_reg;
    logic                                   normed_out_reg;

    logic [gmmf_pkg::FRAC_W-1:0]            cur_frac;
    logic [gmmf_pkg::FRAC_W-1:0]            cur_fin;
    logic signed [gmmf_pkg::SUM_W-1:0]      wsum;
    logic [gmmf_pkg::V_W-1:0]               wpos;
    logic                                   div_done;
    logic [gmmf_pkg::FRAC_W-1:0]            div_quot;
    logic [gmmf_pkg::HACC_W:0]              hround;
    logic [HSH_W-1:0]                       hshift;
    logic [gmmf_pkg::HEAT_W-1:0]            heat_sat;

    assign cur_frac = mole_frac_reg[idx_reg];
    assign cur_fin  = fin_reg[idx_reg];

    // raw weight, negative clamped to zero; a load uses the fraction itself
    assign wsum = $signed({{(gmmf_pkg::SUM_W - gmmf_pkg::OLD_PROD_W){1'b0}}, old_prod_reg})
                + $signed({{(gmmf_pkg::SUM_W - gmmf_pkg::ADD_PROD_W)
                             {add_prod_reg[gmmf_pkg::ADD_PROD_W-1]}}, add_prod_reg});

    always_comb
    begin
        if (opcode_reg == gmmf_pkg::OP_LOAD)
            wpos = gmmf_pkg::V_W'(cur_fin);
        else if (wsum[gmmf_pkg::SUM_W-1])
            wpos = '0;
        else
            wpos = wsum[gmmf_pkg::V_W-1:0];
    end

    gmmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (gmmf_pkg::TOT_W'(v_reg[idx_reg])),
        .den   (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // heat: round half up, saturate
    assign hround   = {1'b0, hacc_reg} + (gmmf_pkg::HACC_W+1)'(32768);
    assign hshift   = hround[gmmf_pkg::HACC_W:gmmf_pkg::HFRAC_BITS];
    assign heat_sat = (|hshift[HSH_W-1:gmmf_pkg::HEAT_W]) ? gmmf_pkg::HEAT_MAX
                                                          : hshift[gmmf_pkg::HEAT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            mole_frac_reg <= '0;
            for (int i = 0; i < gmmf_pkg::NUM_COMPOUNDS; i++)
            begin
                heat_cap_reg[i] <= gmmf_pkg::HEAT_RESET;
            end
        end
        else
        begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.frac_copy)
                mole_frac_reg <= fin_reg;
            else if (cmd.frac_first)
                // all first compound
                mole_frac_reg <= {{((gmmf_pkg::NUM_COMPOUNDS - 1) * gmmf_pkg::FRAC_W){1'b0}},
                                  gmmf_pkg::FRAC_ONE};
            else if (cmd.div_store)
                mole_frac_reg[idx_reg] <= div_quot;

            if (cfg_we && (cfg_index < gmmf_pkg::CFG_IDX_W'(gmmf_pkg::NUM_COMPOUNDS)))
                heat_cap_reg[cfg_index[gmmf_pkg::IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            opcode_reg <= opcode;
            old_reg    <= old_moles;
            add_reg    <= add_moles;
            fin_reg    <= frac_in;
            total_reg  <= '0;
            hacc_reg   <= '0;
        end
        if (cmd.wmul)
        begin
            old_prod_reg <= old_reg * cur_frac;
            add_prod_reg <= add_reg * $signed({1'b0, cur_fin});
        end
        if (cmd.wacc)
        begin
            v_reg[idx_reg] <= wpos;
            total_reg      <= total_reg + gmmf_pkg::TOT_W'(wpos);
        end
        if (cmd.frac_copy)
            normed_reg <= 1'b0;
        else if (cmd.frac_first || cmd.div_start)
            normed_reg <= 1'b1;
        if (cmd.hmul)
            hprod_reg <= heat_cap_reg[idx_reg] * cur_frac;
        if (cmd.hacc)
            hacc_reg <= hacc_reg + gmmf_pkg::HACC_W'(hprod_reg);
        if (cmd.out_load)
        begin
            frac_out_reg   <= mole_frac_reg;
            heat_out_reg   <= heat_sat;
            normed_out_reg <= normed_reg;
        end
    end

    assign stat.idx_last   = (idx_reg == gmmf_pkg::IDX_W'(gmmf_pkg::NUM_COMPOUNDS - 1));
    assign stat.op_load    = (opcode_reg == gmmf_pkg::OP_LOAD);
    assign stat.sum_one    = (total_reg == gmmf_pkg::TOT_W'(gmmf_pkg::FRAC_ONE));
    assign stat.total_zero = (total_reg == '0);
    assign stat.div_done   = div_done;

    assign frac_out       = frac_out_reg;
    assign mix_heat       = heat_out_reg;
    assign was_normalized = normed_out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gmmf_ctrl.sv -----
// gmmf_ctrl: sequencing state machine and output valid flag for the
// mole fraction update; uses gmmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmmf_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire gmmf_pkg::gmmf_stat_t   stat,
    output gmmf_pkg::gmmf_cmd_t         cmd
);

    gmmf_pkg::gmmf_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gmmf_pkg::ST_IDLE:
                if (in_valid)
                    state_next = gmmf_pkg::ST_WMUL;
            gmmf_pkg::ST_WMUL:
                state_next = gmmf_pkg::ST_WACC;
            gmmf_pkg::ST_WACC:
                state_next = stat.idx_last ? gmmf_pkg::ST_CHECK : gmmf_pkg::ST_WMUL;
            gmmf_pkg::ST_CHECK:
                if ((stat.op_load && stat.sum_one) || stat.total_zero)
                    state_next = gmmf_pkg::ST_HMUL;
                else
                    state_next = gmmf_pkg::ST_DIV_START;
            gmmf_pkg::ST_DIV_START:
                state_next = gmmf_pkg::ST_DIV_WAIT;
            gmmf_pkg::ST_DIV_WAIT:
                if (stat.div_done)
                    state_next = stat.idx_last ? gmmf_pkg::ST_HMUL : gmmf_pkg::ST_DIV_START;
            gmmf_pkg::ST_HMUL:
                state_next = gmmf_pkg::ST_HACC;
            gmmf_pkg::ST_HACC:
                state_next = stat.idx_last ? gmmf_pkg::ST_FINISH : gmmf_pkg::ST_HMUL;
            gmmf_pkg::ST_FINISH:
                if (out_free)
                    state_next = gmmf_pkg::ST_IDLE;
            default:
                state_next = gmmf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            gmmf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                end
            end
            gmmf_pkg::ST_WMUL:
                cmd.wmul = 1'b1;
            gmmf_pkg::ST_WACC:
            begin
                cmd.wacc = 1'b1;
                if (stat.idx_last)
                    cmd.idx_clr = 1'b1;
                else
                    cmd.idx_inc = 1'b1;
            end
            gmmf_pkg::ST_CHECK:
                if (stat.op_load && stat.sum_one)
                    cmd.frac_copy = 1'b1;
                else if (stat.total_zero)
                    cmd.frac_first = 1'b1;
            gmmf_pkg::ST_DIV_START:
                cmd.div_start = 1'b1;
            gmmf_pkg::ST_DIV_WAIT:
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (stat.idx_last)
                        cmd.idx_clr = 1'b1;
                    else
                        cmd.idx_inc = 1'b1;
                end
            gmmf_pkg::ST_HMUL:
                cmd.hmul = 1'b1;
            gmmf_pkg::ST_HACC:
            begin
                cmd.hacc = 1'b1;
                if (!stat.idx_last)
                    cmd.idx_inc = 1'b1;
            end
            gmmf_pkg::ST_FINISH:
                if (out_free)
                    cmd.out_load = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmmf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gas_mixture_mole_fraction_update_top.sv -----
// gas_mixture_mole_fraction_update_top: top level joining controller and
// datapath; uses gmmf_pkg, gmmf_ctrl, gmmf_dp (which holds gmmf_div)
//
// request channel (in_valid / in_stall): opcode, old_moles, add_moles and four
//   incoming fractions, taken when in_valid is high and in_stall is low; mix
//   blends added moles into the stored mixture, load takes the given fractions
// result channel (out_valid / out_stall): four new fractions, mix_heat and
//   was_normalized, one per request, held while out_stall is high
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): heat_cap_0..3
//   at index 0..3, other indexes ignored; cfg_ready is always high, writes
//   belong only to idle periods
// timing: one request at a time; a multiply and an accumulate per weight,
//   a check state, then per compound a start and a wait on the shared
//   18-step divider, then a multiply and an accumulate per heat term, then
//   the output load; a load already summing to one or a zero total skips
//   the divides; requests are taken only in idle, so the divider sets the rate
// reset: rst_n clears the stored fractions, sets the heats to 7424 (29.0),
//   idles the state machine and drops out_valid
// stall: a finished result waits in the output register while the next
//   request is accepted and computed; only the finish state waits on out_stall
`timescale 1ns / 1ps
`default_nettype none

module gas_mixture_mole_fraction_update_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [gmmf_pkg::OLD_W-1:0]        old_moles,
    input  wire logic signed [gmmf_pkg::ADD_W-1:0] add_moles,
    input  wire logic [gmmf_pkg::FRAC_W-1:0]       frac_in_0,
    input  wire logic [gmmf_pkg::FRAC_W-1:0]       frac_in_1,
    input  wire logic [gmmf_pkg::FRAC_W-1:0]       frac_in_2,
    input  wire logic [gmmf_pkg::FRAC_W-1:0]       frac_in_3,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [gmmf_pkg::FRAC_W-1:0]            frac_out_0,
    output logic [gmmf_pkg::FRAC_W-1:0]            frac_out_1,
    output logic [gmmf_pkg::FRAC_W-1:0]            frac_out_2,
    output logic [gmmf_pkg::FRAC_W-1:0]            frac_out_3,
    output logic [gmmf_pkg::HEAT_W-1:0]            mix_heat,
    output logic                                   was_normalized,
    // config channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gmmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gmmf_pkg::HEAT_W-1:0]       cfg_data
);

    gmmf_pkg::gmmf_cmd_t  cmd;
    gmmf_pkg::gmmf_stat_t stat;
    gmmf_pkg::frac_vec_t  frac_in;
    gmmf_pkg::frac_vec_t  frac_out;

    // pack the per-compound ports
    assign frac_in[0] = frac_in_0;
    assign frac_in[1] = frac_in_1;
    assign frac_in[2] = frac_in_2;
    assign frac_in[3] = frac_in_3;

    assign frac_out_0 = frac_out[0];
    assign frac_out_1 = frac_out[1];
    assign frac_out_2 = frac_out[2];
    assign frac_out_3 = frac_out[3];

    // heat registers take a write in any cycle
    assign cfg_ready = 1'b1;

    gmmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gmmf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .old_moles      (old_moles),
        .add_moles      (add_moles),
        .frac_in        (frac_in),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frac_out       (frac_out),
        .mix_heat       (mix_heat),
        .was_normalized (was_normalized)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for gas_mixture_mole_fraction_update_top, with an
// in-bench mole fraction and mixture heat predictor and random stalls on both sides
// depends on gmmf_pkg and the top-level rtl only
`timescale 1ns / 1ps

module tb;
    import gmmf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GAP      = 19;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 260;
    localparam int STRETCH      = 50;

    // config register map
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_CAP_3 = CFG_IDX_W'(3);
    localparam int                   REG_UNUSED_LO  = 4;
    localparam int                   REG_UNUSED_HI  = 255;

    typedef struct {
        logic                    op;
        logic [OLD_W-1:0]        old_moles;
        logic signed [ADD_W-1:0] add_moles;
        logic [FRAC_W-1:0]       frac[NUM_COMPOUNDS];
    } mix_request_t;

    typedef struct {
        logic [FRAC_W-1:0] frac[NUM_COMPOUNDS];
        logic [HEAT_W-1:0] heat;
        logic              normed;
    } mix_result_t;

    // dut signals
    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    opcode;
    logic [OLD_W-1:0]        old_moles;
    logic signed [ADD_W-1:0] add_moles;
    logic [FRAC_W-1:0]       frac_in_0;
    logic [FRAC_W-1:0]       frac_in_1;
    logic [FRAC_W-1:0]       frac_in_2;
    logic [FRAC_W-1:0]       frac_in_3;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [FRAC_W-1:0]       frac_out_0;
    logic [FRAC_W-1:0]       frac_out_1;
    logic [FRAC_W-1:0]       frac_out_2;
    logic [FRAC_W-1:0]       frac_out_3;
    logic [HEAT_W-1:0]       mix_heat;
    logic                    was_normalized;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [HEAT_W-1:0]       cfg_data;

    // predictor state: stored fractions and configured heats
    logic [FRAC_W-1:0] model_frac[NUM_COMPOUNDS];
    logic [HEAT_W-1:0] model_heat_cap[NUM_COMPOUNDS];

    // results still owed by the block, oldest first
    mix_result_t expected_mixtures[$];
    int          mismatch_count = 0;

    // idling controls
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic long_hold;
    int   sink_gap = 0;
    event hold_kick;

    gas_mixture_mole_fraction_update_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .old_moles      (old_moles),
        .add_moles      (add_moles),
        .frac_in_0      (frac_in_0),
        .frac_in_1      (frac_in_1),
        .frac_in_2      (frac_in_2),
        .frac_in_3      (frac_in_3),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frac_out_0     (frac_out_0),
        .frac_out_1     (frac_out_1),
        .frac_out_2     (frac_out_2),
        .frac_out_3     (frac_out_3),
        .mix_heat       (mix_heat),
        .was_normalized (was_normalized),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // part*65536/whole rounded half up; wide math so nothing overflows
    function automatic logic [FRAC_W-1:0] rounded_share(longint unsigned part,
                                                        longint unsigned whole);
        logic [127:0] num;
        logic [127:0] quo;
        num = ({64'd0, part} << 17) + {64'd0, whole};
        quo = num / ({64'd0, whole} << 1);
        return quo[FRAC_W-1:0];
    endfunction

    // clamp negatives, rescale to one; empty mixture falls back to compound 0
    function automatic void renormalize(input longint wt[NUM_COMPOUNDS]);
        longint unsigned pos[NUM_COMPOUNDS];
        longint unsigned total;
        int i;
        total = 0;
        for (i = 0; i < NUM_COMPOUNDS; i++)
        begin
            pos[i] = (wt[i] > 0) ? wt[i] : 0;
            total += pos[i];
        end
        for (i = 0; i < NUM_COMPOUNDS; i++)
        begin
            if (total != 0)
                model_frac[i] = rounded_share(pos[i], total);
            else
                model_frac[i] = (i == 0) ? FRAC_ONE : '0;
        end
    endfunction

    // advance the stored mixture by one request and return what the block owes
    function automatic mix_result_t predict_mixture(mix_request_t r);
        longint          wt[NUM_COMPOUNDS];
        longint          oldm;
        longint          addm;
        longint          fr;
        longint          fi;
        longint unsigned load_sum;
        longint unsigned acc;
        longint unsigned term;
        mix_result_t     res;
        int              i;
        res.normed = 1'b1;
        oldm = longint'(r.old_moles);
        addm = longint'(r.add_moles);
        if (r.op == OP_MIX)
        begin
            for (i = 0; i < NUM_COMPOUNDS; i++)
            begin
                fr = longint'(model_frac[i]);
                fi = longint'(r.frac[i]);
                wt[i] = oldm * fr + addm * fi;
            end
            renormalize(wt);
        end
        else
        begin
            load_sum = 0;
            for (i = 0; i < NUM_COMPOUNDS; i++)
                load_sum += 64'(r.frac[i]);
            if (load_sum == FRAC_ONE)
            begin
                for (i = 0; i < NUM_COMPOUNDS; i++)
                    model_frac[i] = r.frac[i];
                res.normed = 1'b0;
            end
            else
            begin
                for (i = 0; i < NUM_COMPOUNDS; i++)
                    wt[i] = longint'(r.frac[i]);
                renormalize(wt);
            end
        end
        // Q8.8 heat times Q1.16 fraction, back to Q8.8 with half up, saturating
        acc = 0;
        for (i = 0; i < NUM_COMPOUNDS; i++)
        begin
            term = 64'(model_heat_cap[i]);
            acc += term * 64'(model_frac[i]);
            res.frac[i] = model_frac[i];
        end
        acc = (acc + 32768) >> 16;
        res.heat = (acc > HEAT_MAX) ? HEAT_MAX : acc[HEAT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall, long hold-off, checking
    // ------------------------------------------------------------------

    task automatic show_result(input string tag, input mix_result_t r);
        $display("  %s frac %0d %0d %0d %0d heat %0d normalized %0d", tag,
                 r.frac[0], r.frac[1], r.frac[2], r.frac[3], r.heat, r.normed);
    endtask

    task automatic check_result(input mix_result_t got);
        mix_result_t want;
        logic        bad;
        int          i;
        if (expected_mixtures.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("result with no request outstanding at %0t", $realtime);
                show_result("actual  ", got);
            end
        end
        else
        begin
            want = expected_mixtures.pop_front();
            bad = (got.heat !== want.heat) || (got.normed !== want.normed);
            for (i = 0; i < NUM_COMPOUNDS; i++)
                bad = bad || (got.frac[i] !== want.frac[i]);
            if (bad)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("result mismatch at %0t", $realtime);
                    show_result("expected", want);
                    show_result("actual  ", got);
                end
            end
        end
    endtask

    // long hold-off: counted here, kicked from the test sequence
    initial
    begin : hold_off_timer
        long_hold = 1'b0;
        forever
        begin
            @(hold_kick);
            @(posedge clk);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            long_hold <= 1'b0;
        end
    end

    // accept results, draw a stall for the next one
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        mix_result_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.frac[0] = frac_out_0;
                got.frac[1] = frac_out_1;
                got.frac[2] = frac_out_2;
                got.frac[3] = frac_out_3;
                got.heat    = mix_heat;
                got.normed  = was_normalized;
                check_result(got);
                sink_gap = rx_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap--;
            end
            out_stall <= long_hold || (sink_gap != 0);
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // present one request and hold it until taken; valid stays up for back-to-back
    task automatic send_request(input mix_request_t r);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, MAX_GAP)) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_mixtures.push_back(predict_mixture(r));
        in_valid  <= 1'b1;
        opcode    <= r.op;
        old_moles <= r.old_moles;
        add_moles <= r.add_moles;
        frac_in_0 <= r.frac[0];
        frac_in_1 <= r.frac[1];
        frac_in_2 <= r.frac[2];
        frac_in_3 <= r.frac[3];
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering and let every owed result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_mixtures.size() != 0)
            @(posedge clk);
    endtask

    function automatic mix_request_t make_request(logic op, logic [OLD_W-1:0] om,
                                                  logic signed [ADD_W-1:0] am,
                                                  logic [FRAC_W-1:0] f0,
                                                  logic [FRAC_W-1:0] f1,
                                                  logic [FRAC_W-1:0] f2,
                                                  logic [FRAC_W-1:0] f3);
        mix_request_t r;
        r.op        = op;
        r.old_moles = om;
        r.add_moles = am;
        r.frac[0]   = f0;
        r.frac[1]   = f1;
        r.frac[2]   = f2;
        r.frac[3]   = f3;
        return r;
    endfunction

    // mostly well-formed fraction sets, some raw or tiny ones for edge rounding
    function automatic mix_request_t random_request();
        mix_request_t      r;
        logic [31:0]       raw;
        logic [FRAC_W-1:0] left;
        int                pick;
        int                fmode;
        int                start;
        int                s;
        int                k;
        pick  = $urandom_range(0, 99);
        fmode = $urandom_range(0, 9);
        r.op  = (pick < 45) ? OP_LOAD : OP_MIX;

        if (fmode <= 5)
        begin
            start = $urandom_range(0, NUM_COMPOUNDS - 1);
            left  = FRAC_ONE;
            for (k = 0; k < NUM_COMPOUNDS - 1; k++)
            begin
                r.frac[(start + k) % NUM_COMPOUNDS] = FRAC_W'($urandom_range(0, left));
                left -= r.frac[(start + k) % NUM_COMPOUNDS];
            end
            r.frac[(start + NUM_COMPOUNDS - 1) % NUM_COMPOUNDS] = left;
        end
        else
        begin
            for (k = 0; k < NUM_COMPOUNDS; k++)
            begin
                raw = $urandom;
                case (fmode)
                    6, 7:    r.frac[k] = raw[FRAC_W-1:0];
                    8:       r.frac[k] = FRAC_W'(raw[1:0]);
                    default: r.frac[k] = model_frac[k];
                endcase
            end
        end

        // existing moles: zero, small, whole-mole steps, or anything
        raw = $urandom;
        case ($urandom_range(0, 9))
            0:          r.old_moles = '0;
            1, 2, 3:    r.old_moles = OLD_W'($urandom_range(0, 65536));
            4, 5, 6:    r.old_moles = raw[OLD_W-1:0];
            default:    r.old_moles = OLD_W'(4096 * $urandom_range(0, 64));
        endcase

        // added moles, including removal of exactly what is there
        raw = $urandom;
        case ($urandom_range(0, 9))
            0:          r.add_moles = '0;
            1:
            begin
                r.add_moles = -$signed({1'b0, r.old_moles});
                if ($urandom_range(0, 1) == 1)
                    for (k = 0; k < NUM_COMPOUNDS; k++)
                        r.frac[k] = model_frac[k];
            end
            2, 3:       r.add_moles = raw;
            4, 5, 6:
            begin
                s = int'($urandom_range(0, 131072)) - 65536;
                r.add_moles = s;
            end
            default:
            begin
                s = (int'($urandom_range(0, 128)) - 64) * 4096;
                r.add_moles = s;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // config writes, only while idle
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HEAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx <= REG_HEAT_CAP_3)
            model_heat_cap[idx[IDX_W-1:0]] = val;
    endtask

    // all four heats, then a write to an unmapped index that must be dropped
    task automatic program_heat_caps(input logic [HEAT_W-1:0] h0, input logic [HEAT_W-1:0] h1,
                                     input logic [HEAT_W-1:0] h2, input logic [HEAT_W-1:0] h3);
        logic [31:0] raw;
        raw = $urandom;
        write_reg(REG_HEAT_CAP_0, h0);
        write_reg(REG_HEAT_CAP_1, h1);
        write_reg(REG_HEAT_CAP_2, h2);
        write_reg(REG_HEAT_CAP_3, h3);
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), raw[HEAT_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [HEAT_W-1:0] random_heat();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HEAT_MAX;
            default: return raw[HEAT_W-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked corners under the reset heats
    task automatic test_directed_cases();
        tx_idle_on = 1'b1;
        // empty store, nothing added: falls back to all compound 0
        send_request(make_request(OP_MIX, '0, '0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        // loads that already sum to one pass through untouched
        send_request(make_request(OP_LOAD, '0, '0, FRAC_ONE, '0, '0, '0));
        send_request(make_request(OP_LOAD, '0, '0, 16384, 16384, 16384, 16384));
        // all zero load
        send_request(make_request(OP_LOAD, '0, '0, '0, '0, '0, '0));
        // out of range fractions
        send_request(make_request(OP_LOAD, '0, '0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        // exact half rounds up
        send_request(make_request(OP_LOAD, '0, '0, 1, '0, '0, 17'h1FFFF));
        // thirds, and a set whose rounded shares overshoot one
        send_request(make_request(OP_LOAD, '0, '0, 1, 2, '0, '0));
        send_request(make_request(OP_LOAD, '0, '0, 1, 1, 1, 3));
        // one short, one over and one exact
        send_request(make_request(OP_LOAD, '0, '0, 65535, '0, '0, '0));
        send_request(make_request(OP_LOAD, '0, '0, '0, '0, '0, 65537));
        send_request(make_request(OP_LOAD, '0, '0, 32768, 32768, '0, '0));
        // removal drives compound 0 negative, clamped
        send_request(make_request(OP_MIX, 4096, -32'sd4096, FRAC_ONE, '0, '0, '0));
        // largest magnitudes
        send_request(make_request(OP_MIX, 31'h7FFFFFFF, 32'sh7FFFFFFF,
                                  17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        send_request(make_request(OP_MIX, 31'h7FFFFFFF, 32'sh80000000,
                                  17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF));
        // only removal, nothing left
        send_request(make_request(OP_MIX, '0, 32'sh80000000, FRAC_ONE, '0, '0, '0));
        // ordinary blend
        send_request(make_request(OP_LOAD, '0, '0, 32768, 32768, '0, '0));
        send_request(make_request(OP_MIX, 4096, 4096, '0, '0, '0, FRAC_ONE));
        send_request(make_request(OP_MIX, 31'h7FFFFFFF, 1, '0, '0, FRAC_ONE, '0));
        // remove exactly the stored mixture: zero total
        send_request(make_request(OP_MIX, 8192, -32'sd8192,
                                  model_frac[0], model_frac[1], model_frac[2], model_frac[3]));
        wait_drained();
    endtask

    // heat sum at its limits, including saturation
    task automatic test_heat_extremes();
        int n;
        program_heat_caps(HEAT_MAX, HEAT_MAX, HEAT_MAX, HEAT_MAX);
        send_request(make_request(OP_LOAD, '0, '0, 1, 1, 1, 3));
        send_request(make_request(OP_LOAD, '0, '0, FRAC_ONE, '0, '0, '0));
        for (n = 0; n < 8; n++)
            send_request(random_request());
        wait_drained();
        program_heat_caps('0, '0, '0, '0);
        for (n = 0; n < 5; n++)
            send_request(random_request());
        wait_drained();
        program_heat_caps(HEAT_MAX, '0, 1, 16'h8000);
        send_request(make_request(OP_LOAD, '0, '0, 1, 1, 1, 3));
        for (n = 0; n < 8; n++)
            send_request(random_request());
        wait_drained();
    endtask

    // receiver stops for a long while, sender keeps pushing until the input stalls
    task automatic test_output_backpressure();
        int n;
        tx_idle_on = 1'b0;
        -> hold_kick;
        for (n = 0; n < 40; n++)
            send_request(random_request());
        wait_drained();
    endtask

    // random traffic in phases, fresh heats per phase, idling switched per stretch
    task automatic test_random_traffic();
        int p;
        int n;
        for (p = 0; p < PHASES; p++)
        begin
            program_heat_caps(random_heat(), random_heat(), random_heat(), random_heat());
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % STRETCH == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on <= ($urandom_range(0, 2) != 0);
                end
                send_request(random_request());
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        int i;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = OP_MIX;
        old_moles = '0;
        add_moles = '0;
        frac_in_0 = '0;
        frac_in_1 = '0;
        frac_in_2 = '0;
        frac_in_3 = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        // predictor reset state
        for (i = 0; i < NUM_COMPOUNDS; i++)
        begin
            model_frac[i]     = '0;
            model_heat_cap[i] = HEAT_RESET;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_heat_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        // catch anything spurious that trails the last result
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_mixtures.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gmmf_pkg.sv
hw/rtl/gmmf_div.sv
hw/rtl/gmmf_dp.sv
hw/rtl/gmmf_ctrl.sv
hw/rtl/gas_mixture_mole_fraction_update_top.sv
tb/sv/tb.sv
